// ===== hw/rtl/scc_pkg.sv =====
`default_nettype none
package scc_pkg;

   localparam int MaxNodesDefault = 64;
   localparam int MaxEdgesDefault = 256;

   localparam logic [1:0] ModeAdd   = 2'd0;
   localparam logic [1:0] ModeRun   = 2'd1;
   localparam logic [1:0] ModeClear = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [5:0] src_node;
      logic [5:0] dst_node;
   } req_type;

   typedef struct packed {
      logic [5:0] node_id;
      logic [5:0] component_id;
      logic       edge_overflow;
      logic       last;
   } rsp_type;

endpackage
`default_nettype wire

// ===== hw/rtl/scc_ram.sv =====
`default_nettype none
module scc_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(Depth)-1:0] wr_addr,
   input  wire [Width-1:0]         wr_data,
   input  wire [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]        rd_data
);
   logic [Width-1:0] mem [Depth];

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/strongly_connected_components.sv =====
// Channel | Direction | Handshake           | Payload
// req     | in        | start / busy        | scc_pkg::req_type
// rsp     | out       | rsp_valid strobe    | scc_pkg::rsp_type
// csr     | in        | csr_valid/csr_ready | node_count, 7 bits
//
// An add reads the edge table entry by entry through S_ADD_RD and S_ADD_CHK looking for a
// duplicate, and busy stays high while it scans. Clear and the unused mode finish at the
// accepting edge. A run clears the node flags in S_INIT, scans the edge table through
// S_EDGE_RD and S_EDGE_CHK for every frame, pops each component member through S_POP_RD
// and S_POP_WR, then emits one result a cycle. Reset is synchronous and needs no clearing
// pass; the receiver cannot stall.
`default_nettype none
module strongly_connected_components #(
   parameter int MaxNodes = scc_pkg::MaxNodesDefault,
   parameter int MaxEdges = scc_pkg::MaxEdgesDefault
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  scc_pkg::req_type   req_payload,
   output logic               rsp_valid,
   output scc_pkg::rsp_type   rsp_payload,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire  [6:0]         csr_node_count
);
   import scc_pkg::*;

   localparam int NW = $clog2(MaxNodes);
   localparam int EW = $clog2(MaxEdges);

   typedef enum logic [3:0] {
      S_IDLE, S_ADD_RD, S_ADD_CHK, S_INIT, S_OUTER, S_EDGE_RD, S_EDGE_CHK,
      S_VIS_CHK, S_POP_RD, S_POP_WR, S_RET, S_RESUME, S_EMIT_RD, S_EMIT
   } state_type;

   // Saved state of a suspended search frame.
   typedef struct packed {
      logic [5:0]  node;
      logic [EW:0] pos;
      logic [5:0]  low;
      logic [5:0]  idx;
   } frame_type;

   state_type      state_ff;
   logic [6:0]     node_count_ff;
   logic [EW:0]    edge_count_ff;
   logic           overflow_ff;
   logic [EW:0]    eidx_ff;
   logic [11:0]    key_ff;
   logic [6:0]     n_ff;
   logic [NW:0]    iter_ff;
   logic [6:0]     next_index_ff;
   logic [NW:0]    sdepth_ff;
   logic [NW:0]    fdepth_ff;
   logic [5:0]     v_ff;
   logic [5:0]     vidx_ff;
   logic [5:0]     vlow_ff;
   logic [MaxNodes-1:0] visited_ff;
   logic [MaxNodes-1:0] onstk_ff;

   logic           e_we;
   logic [EW-1:0]  e_waddr, e_raddr;
   logic [11:0]    e_rdata;

   logic [5:0]     esrc, edst;
   logic [NW-1:0]  dn;
   logic           outer_open, edge_hit, edge_open, node_open;
   logic [NW-1:0]  vis_waddr;
   logic [5:0]     vis_rdata;
   logic [NW-1:0]  stk_waddr, stk_raddr;
   logic [5:0]     stk_wdata, stk_rdata;
   logic [NW-1:0]  frm_waddr, frm_raddr;
   frame_type      frm_wdata, frm_rdata;
   logic           comp_we;
   logic [NW-1:0]  comp_raddr;
   logic [5:0]     comp_rdata;

   // Edge table memory.
   scc_ram #(.Width(12), .Depth(MaxEdges)) u_edges (
      .clock(clock), .wr_en(e_we), .wr_addr(e_waddr), .wr_data(key_ff),
      .rd_addr(e_raddr), .rd_data(e_rdata)
   );

   // DFS index of every opened node, looked up when an edge reaches an on-stack node.
   scc_ram #(.Width(6), .Depth(MaxNodes)) u_vis (
      .clock(clock), .wr_en(node_open), .wr_addr(vis_waddr), .wr_data(next_index_ff[5:0]),
      .rd_addr(dn), .rd_data(vis_rdata)
   );

   // Node stack of the search.
   scc_ram #(.Width(6), .Depth(MaxNodes)) u_stack (
      .clock(clock), .wr_en(node_open), .wr_addr(stk_waddr), .wr_data(stk_wdata),
      .rd_addr(stk_raddr), .rd_data(stk_rdata)
   );

   // Suspended frames; the current frame lives in registers.
   scc_ram #(.Width($bits(frame_type)), .Depth(MaxNodes)) u_frames (
      .clock(clock), .wr_en(edge_open), .wr_addr(frm_waddr), .wr_data(frm_wdata),
      .rd_addr(frm_raddr), .rd_data(frm_rdata)
   );

   // Component id of every node, written as nodes are popped.
   scc_ram #(.Width(6), .Depth(MaxNodes)) u_comp (
      .clock(clock), .wr_en(comp_we), .wr_addr(stk_rdata[NW-1:0]), .wr_data(vidx_ff),
      .rd_addr(comp_raddr), .rd_data(comp_rdata)
   );

   assign e_raddr  = eidx_ff[EW-1:0];
   assign e_waddr  = edge_count_ff[EW-1:0];
   assign e_we     = (state_ff == S_ADD_RD) && (eidx_ff == edge_count_ff)
                     && (edge_count_ff < (EW+1)'(MaxEdges));
   assign busy     = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);

   assign esrc = e_rdata[11:6];
   assign edst = e_rdata[5:0];
   assign dn   = edst[NW-1:0];

   // A node is opened either as a new root or as the target of an edge.
   assign outer_open = (state_ff == S_OUTER) && (iter_ff < (NW+1)'(n_ff))
                       && !visited_ff[iter_ff[NW-1:0]];
   assign edge_hit   = (state_ff == S_EDGE_CHK) && (esrc == v_ff) && ({1'b0, edst} < n_ff);
   assign edge_open  = edge_hit && !visited_ff[dn];
   assign node_open  = outer_open || edge_open;

   assign vis_waddr  = outer_open ? iter_ff[NW-1:0] : dn;
   assign stk_waddr  = outer_open ? '0 : sdepth_ff[NW-1:0];
   assign stk_wdata  = outer_open ? 6'(iter_ff) : edst;
   assign stk_raddr  = sdepth_ff[NW-1:0] - NW'(1);
   assign frm_waddr  = fdepth_ff[NW-1:0] - NW'(1);
   assign frm_raddr  = fdepth_ff[NW-1:0] - NW'(2);
   assign frm_wdata  = {v_ff, eidx_ff + (EW+1)'(1), vlow_ff, vidx_ff};
   assign comp_we    = (state_ff == S_POP_WR);
   // Results stream one a cycle, so the read runs one node ahead while emitting.
   assign comp_raddr = (state_ff == S_EMIT) ? iter_ff[NW-1:0] + NW'(1) : iter_ff[NW-1:0];

   // Sequencer.
   always_ff @(posedge clock) begin
      rsp_valid <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
         node_count_ff <= '0;
         edge_count_ff <= '0;
         overflow_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            node_count_ff <= csr_node_count;
         end
         unique case (state_ff)
            S_IDLE: if (start) begin
               key_ff <= {req_payload.src_node, req_payload.dst_node};
               eidx_ff <= '0;
               iter_ff <= '0;
               n_ff <= (node_count_ff > 7'(MaxNodes)) ? 7'(MaxNodes) : node_count_ff;
               case (req_payload.mode)
                  ModeAdd: state_ff <= S_ADD_RD;
                  ModeRun: state_ff <= S_INIT;
                  ModeClear: begin
                     edge_count_ff <= '0;
                     overflow_ff <= 1'b0;
                  end
                  default: ;
               endcase
            end
            S_ADD_RD: begin
               if (eidx_ff == edge_count_ff) begin
                  if (edge_count_ff < (EW+1)'(MaxEdges)) begin
                     edge_count_ff <= edge_count_ff + 1'b1;
                  end else begin
                     overflow_ff <= 1'b1;
                  end
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_ADD_CHK;
               end
            end
            S_ADD_CHK: begin
               if (e_rdata == key_ff) begin
                  state_ff <= S_IDLE;
               end else begin
                  eidx_ff <= eidx_ff + 1'b1;
                  state_ff <= S_ADD_RD;
               end
            end
            S_INIT: begin
               visited_ff <= '0;
               onstk_ff <= '0;
               next_index_ff <= '0;
               sdepth_ff <= '0;
               fdepth_ff <= '0;
               iter_ff <= '0;
               state_ff <= S_OUTER;
            end
            S_OUTER: begin
               if (iter_ff >= (NW+1)'(n_ff)) begin
                  iter_ff <= '0;
                  state_ff <= (n_ff == 7'd0) ? S_IDLE : S_EMIT_RD;
               end else if (visited_ff[iter_ff[NW-1:0]]) begin
                  iter_ff <= iter_ff + 1'b1;
               end else begin
                  // Visit the root; its index and stack slot are written to memory.
                  visited_ff[iter_ff[NW-1:0]] <= 1'b1;
                  onstk_ff[iter_ff[NW-1:0]] <= 1'b1;
                  sdepth_ff <= (NW+1)'(1);
                  fdepth_ff <= (NW+1)'(1);
                  next_index_ff <= next_index_ff + 1'b1;
                  v_ff <= 6'(iter_ff);
                  vidx_ff <= next_index_ff[5:0];
                  vlow_ff <= next_index_ff[5:0];
                  eidx_ff <= '0;
                  state_ff <= S_EDGE_RD;
               end
            end
            // Address the next table entry; past the end the frame is finished.
            S_EDGE_RD: begin
               if (eidx_ff >= edge_count_ff) begin
                  state_ff <= (vlow_ff == vidx_ff) ? S_POP_RD : S_RET;
               end else begin
                  state_ff <= S_EDGE_CHK;
               end
            end
            S_EDGE_CHK: begin
               if (!edge_hit) begin
                  eidx_ff <= eidx_ff + 1'b1;
                  state_ff <= S_EDGE_RD;
               end else if (edge_open) begin
                  // Descend: the current frame is saved and the target becomes current.
                  visited_ff[dn] <= 1'b1;
                  onstk_ff[dn] <= 1'b1;
                  sdepth_ff <= sdepth_ff + 1'b1;
                  fdepth_ff <= fdepth_ff + 1'b1;
                  next_index_ff <= next_index_ff + 1'b1;
                  v_ff <= edst;
                  vidx_ff <= next_index_ff[5:0];
                  vlow_ff <= next_index_ff[5:0];
                  eidx_ff <= '0;
                  state_ff <= S_EDGE_RD;
               end else if (onstk_ff[dn]) begin
                  state_ff <= S_VIS_CHK;
               end else begin
                  eidx_ff <= eidx_ff + 1'b1;
                  state_ff <= S_EDGE_RD;
               end
            end
            // The target is on the stack, so its index may lower the low link.
            S_VIS_CHK: begin
               if (vis_rdata < vlow_ff) begin
                  vlow_ff <= vis_rdata;
               end
               eidx_ff <= eidx_ff + 1'b1;
               state_ff <= S_EDGE_RD;
            end
            // Pop the component one node at a time through S_POP_RD and S_POP_WR when v is a root.
            S_POP_RD: state_ff <= S_POP_WR;
            S_POP_WR: begin
               onstk_ff[stk_rdata[NW-1:0]] <= 1'b0;
               sdepth_ff <= sdepth_ff - 1'b1;
               state_ff <= (stk_rdata == v_ff) ? S_RET : S_POP_RD;
            end
            // Return to the parent frame, which is read from memory; a root frame goes back to the outer loop.
            S_RET: begin
               fdepth_ff <= fdepth_ff - 1'b1;
               if (fdepth_ff == (NW+1)'(1)) begin
                  iter_ff <= iter_ff + 1'b1;
                  state_ff <= S_OUTER;
               end else begin
                  state_ff <= S_RESUME;
               end
            end
            // The parent takes the child's low link when it is smaller.
            S_RESUME: begin
               v_ff <= frm_rdata.node;
               vidx_ff <= frm_rdata.idx;
               vlow_ff <= (vlow_ff < frm_rdata.low) ? vlow_ff : frm_rdata.low;
               eidx_ff <= frm_rdata.pos;
               state_ff <= S_EDGE_RD;
            end
            S_EMIT_RD: state_ff <= S_EMIT;
            S_EMIT: begin
               rsp_valid <= 1'b1;
               rsp_payload.node_id <= 6'(iter_ff);
               rsp_payload.component_id <= comp_rdata;
               rsp_payload.edge_overflow <= overflow_ff;
               rsp_payload.last <= ((iter_ff + 1'b1) == (NW+1)'(n_ff));
               iter_ff <= iter_ff + 1'b1;
               if ((iter_ff + 1'b1) == (NW+1)'(n_ff)) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
